FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hdl/bsvp_pkg.sv
// ----------------------------------------------------------------------------
// bsvp_pkg
// Codes, default sizes and controller/datapath signal groups for the
// bounded stack with value purge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsvp_pkg;

  // default number of stack entries
  localparam int DEFAULT_DEPTH = 128;

  // field widths
  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PURGE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic accept_push;   // push request taken
    logic accept_pop;    // pop request taken
    logic accept_purge;  // purge request taken
    logic accept_other;  // unused action code taken
    logic pop_finish;    // read data of the popped entry is ready
    logic purge_read;    // read entry at the purge read pointer
    logic purge_step;    // compare entry, compact, advance
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic purge_last;    // current purge entry is the top one
    logic out_free;      // result register empty or being taken
  } stat_t;

endpackage

FILE: hdl/bsvp_if.sv
// ----------------------------------------------------------------------------
// bsvp_if
// Valid/ready channels: request channel (action, value) and result
// channel (popped value, status, entry count).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsvp_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [bsvp_pkg::ACTION_W-1:0]        action;
  logic signed [bsvp_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface bsvp_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bsvp_pkg::VALUE_W-1:0]  popped_value;
  logic [bsvp_pkg::STATUS_W-1:0]        status;
  logic [bsvp_pkg::COUNT_W-1:0]         entry_count;

  modport source (output valid, output popped_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input popped_value, input status,
                  input entry_count, output ready);
endinterface

FILE: hdl/bsvp_ctrl.sv
// ----------------------------------------------------------------------------
// bsvp_ctrl
// Sequencer: takes requests, runs the pop read and the purge walk, and
// issues datapath commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsvp_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [bsvp_pkg::ACTION_W-1:0] req_action,
  output logic                          req_ready,
  input  bsvp_pkg::stat_t               stat,
  output bsvp_pkg::cmd_t                cmd
);

  typedef enum logic [1:0] {
    IDLE,
    POP_DATA,
    PURGE_RD,
    PURGE_CMP
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // take a request only when idle and the result slot is free
  assign req_ready = (state == IDLE) && stat.out_free;
  assign accept    = req_valid && req_ready;

  // command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: begin
        if (accept) begin
          unique case (req_action)
            bsvp_pkg::ACT_PUSH:  cmd.accept_push  = 1'b1;
            bsvp_pkg::ACT_POP:   cmd.accept_pop   = 1'b1;
            bsvp_pkg::ACT_PURGE: cmd.accept_purge = 1'b1;
            default:             cmd.accept_other = 1'b1;
          endcase
        end
      end
      POP_DATA:  cmd.pop_finish = 1'b1;
      PURGE_RD:  cmd.purge_read = 1'b1;
      PURGE_CMP: cmd.purge_step = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: begin
        if (cmd.accept_pop && !stat.empty) begin
          state_next = POP_DATA;
        end else if (cmd.accept_purge && !stat.empty) begin
          state_next = PURGE_RD;
        end
      end
      POP_DATA:  state_next = IDLE;
      PURGE_RD:  state_next = PURGE_CMP;
      PURGE_CMP: state_next = stat.purge_last ? IDLE : PURGE_RD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/bsvp_dp.sv
// ----------------------------------------------------------------------------
// bsvp_dp
// Stack datapath: entry memory, depth counter, purge pointers and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsvp_dp #(
  parameter int DEPTH = bsvp_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bsvp_pkg::cmd_t                      cmd,
  input  logic signed [bsvp_pkg::VALUE_W-1:0] req_value,
  output bsvp_pkg::stat_t                     stat,
  bsvp_res_if.source                          result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [bsvp_pkg::VALUE_W-1:0] mem [DEPTH];

  logic [CW-1:0]                       count;
  logic [CW-1:0]                       count_next;
  logic [CW-1:0]                       count_dec;
  logic [CW-1:0]                       rd;
  logic [CW-1:0]                       wr;
  logic [CW-1:0]                       wr_new;
  logic signed [bsvp_pkg::VALUE_W-1:0] key;
  logic signed [bsvp_pkg::VALUE_W-1:0] rdata;
  logic [AW-1:0]                       rd_addr;
  logic                                rd_en;
  logic                                keep;
  logic                                res_load;
  logic [CW+bsvp_pkg::COUNT_W-1:0]     count_ext;
  logic                                out_valid;

  // status toward the controller
  assign stat.full       = (count == CW'(DEPTH));
  assign stat.empty      = (count == '0);
  assign stat.purge_last = (rd == count_dec);
  assign stat.out_free   = !out_valid || result.ready;

  assign count_dec = count - CW'(1);

  // purge compare: keep entries that differ from the key
  assign keep   = (rdata != key);
  assign wr_new = wr + CW'(keep);

  // read port address: top entry on pop, walk pointer on purge
  assign rd_en   = (cmd.accept_pop && !stat.empty) || cmd.purge_read;
  assign rd_addr = cmd.purge_read ? rd[AW-1:0] : count_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // single write port: push on top, or compacting write during purge
  always_ff @(posedge clk) begin
    if (cmd.accept_push && !stat.full) begin
      mem[count[AW-1:0]] <= req_value;
    end else if (cmd.purge_step && keep) begin
      mem[wr[AW-1:0]] <= rdata;
    end
  end

  // depth count after this cycle
  always_comb begin
    count_next = count;
    if (cmd.accept_push && !stat.full) begin
      count_next = count + CW'(1);
    end else if (cmd.accept_pop && !stat.empty) begin
      count_next = count_dec;
    end else if (cmd.purge_step && stat.purge_last) begin
      count_next = wr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // purge pointers and key
  always_ff @(posedge clk) begin
    if (cmd.accept_purge) begin
      key <= req_value;
      rd  <= '0;
      wr  <= '0;
    end else if (cmd.purge_step) begin
      rd <= rd + CW'(1);
      wr <= wr_new;
    end
  end

  // a result is ready this cycle
  assign res_load = cmd.accept_push || cmd.accept_other || cmd.pop_finish
                 || ((cmd.accept_pop || cmd.accept_purge) && stat.empty)
                 || (cmd.purge_step && stat.purge_last);

  assign count_ext = {{bsvp_pkg::COUNT_W{1'b0}}, count_next};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.popped_value <= cmd.pop_finish ? rdata : '0;
      result.entry_count  <= count_ext[bsvp_pkg::COUNT_W-1:0];
      if (cmd.accept_push && stat.full) begin
        result.status <= bsvp_pkg::ST_FULL;
      end else if (cmd.accept_pop && stat.empty) begin
        result.status <= bsvp_pkg::ST_EMPTY;
      end else begin
        result.status <= bsvp_pkg::ST_OK;
      end
    end
  end

  assign result.valid = out_valid;

  // checks
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `ASSERT_SAME(a_compact_behind, clk, rst, cmd.purge_step, (wr <= rd) && (rd < count))
  `ASSERT_NEXT(a_result_shown, clk, rst, res_load, out_valid)
  `ASSERT_SAME(a_no_overwrite, clk, rst, res_load, stat.out_free)

endmodule

FILE: hdl/bounded_stack_with_value_purge.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_value_purge
// Bounded LIFO of signed 32-bit words with push, pop and purge-by-value.
//
//   channel   dir   payload                              handshake
//   request   in    action[1:0], value[31:0]             valid/ready
//   result    out   popped_value[31:0], status[1:0],     valid/ready
//                   entry_count[7:0]
//
// Push and unused codes are answered on acceptance. Pop adds a registered
// memory read, and is answered on acceptance on an empty stack.
// Purge: one read then one compare/compact write per held entry, through
// the memory's single port pair; an empty stack is answered on acceptance.
// Reset clears the depth count, the sequencer and the result valid; the
// entry memory is not cleared.
// A request is taken only when idle and the result register is empty or
// is being taken in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_stack_with_value_purge #(
  parameter int STACK_DEPTH = bsvp_pkg::DEFAULT_DEPTH
) (
  input logic        clk,
  input logic        rst,
  bsvp_req_if.sink   request,
  bsvp_res_if.source result
);

  bsvp_pkg::cmd_t  cmd;
  bsvp_pkg::stat_t stat;

  bsvp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (request.valid),
    .req_action (request.action),
    .req_ready  (request.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bsvp_dp #(
    .DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_value (request.value),
    .stat      (stat),
    .result    (result)
  );

endmodule
